@@ design/u16u8_pkg.sv @@
package u16u8_pkg;

  localparam int COUNT_BITS = 24;
  localparam int CAP_W      = 24;
  localparam int CMP_W      = (COUNT_BITS > CAP_W ? COUNT_BITS : CAP_W) + 1;
  localparam int CP_W       = 21;
  localparam int NB_W       = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};

  // upper six bits of a utf-16 surrogate
  localparam logic [5:0] HI_SUR_TAG = 6'b110110;
  localparam logic [5:0] LO_SUR_TAG = 6'b110111;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HELD,
    PH_UNIT,
    PH_END
  } ph_e;

  // one character or one end marker for the byte side
  typedef struct packed {
    logic                 is_end;
    logic [CP_W-1:0]      cp;
    logic [NB_W-1:0]      nb;
    logic [CAP_W-1:0]     count;
    logic                 trunc;
  } cmd_t;

endpackage

@@ design/u16u8_in_if.sv @@
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, output code_unit, output last_unit, input ready);
  modport sink (input valid, input code_unit, input last_unit, output ready);
endinterface

@@ design/u16u8_out_if.sv @@
interface u16u8_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        end_of_string;
  logic [23:0] written_count;
  logic        truncated;

  modport source (output valid, output out_byte, output end_of_string,
                  output written_count, output truncated, input ready);
  modport sink (input valid, input out_byte, input end_of_string,
                input written_count, input truncated, output ready);
endinterface

@@ design/inverted_utf16_to_utf8_top.sv @@
// channel   dir   handshake      payload
// in_i      in    valid/ready    code_unit[15:0], last_unit
// out_o     out   valid/ready    out_byte[7:0], end_of_string, written_count[23:0], truncated
// cfg       in    cfg_we_i       cfg_data_i[23:0] (out_capacity)
//
// the front takes one step per code unit, one more when a held high surrogate is
// flushed alone and one more for the end word; each step queues at most one word
// the back sends one byte per cycle while out_o is ready, so a unit yields 0 to 7 bytes,
// about 3 for text outside ascii
// a 2-deep queue and the registered output let each side stall independently
// rst_ni clears all string state and sets the capacity to its maximum
module inverted_utf16_to_utf8_top
  import u16u8_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  u16u8_in_if.sink         in_i,
  u16u8_out_if.source      out_o
);

  logic push;
  cmd_t push_cmd;
  logic fifo_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  u16u8_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_cmd_o  (push_cmd)
  );

  u16u8_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

@@ design/u16u8_fifo.sv @@
module u16u8_fifo
  import u16u8_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic head_valid_o,
  output cmd_t head_cmd_o
);

  cmd_t                 mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, wptr_d;
  logic [FIFO_AW-1:0]   rptr_q, rptr_d;
  logic [FIFO_CW-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ design/u16u8_front.sv @@
module u16u8_front
  import u16u8_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  u16u8_in_if.sink          in_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output cmd_t              push_cmd_o
);

  logic                  item_v_q, item_v_d;
  logic [15:0]           unit_q, unit_d;
  logic                  last_q, last_d;
  ph_e                   ph_q, ph_d;
  logic                  held_q, held_d;
  logic [9:0]            held_bits_q, held_bits_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  stopped_q, stopped_d;
  logic [CAP_W-1:0]      cap_q;

  logic                  step;
  logic                  fin;
  logic                  accept;
  logic                  is_low, is_high;
  logic [CP_W-1:0]       pair_cp;
  logic [CP_W-1:0]       char_cp;
  logic [NB_W-1:0]       nb;
  logic [CMP_W-1:0]      lim, cap_ext, eff_cap, sum;
  logic                  fits;

  assign step    = item_v_q && !fifo_full_i;
  assign is_low  = (unit_q[15:10] == LO_SUR_TAG);
  assign is_high = (unit_q[15:10] == HI_SUR_TAG);
  assign pair_cp = CP_W'({held_bits_q, unit_q[9:0]}) + CP_W'(21'h10000);
  assign char_cp = (ph_q == PH_HELD)
                   ? (is_low ? pair_cp : CP_W'({HI_SUR_TAG, held_bits_q}))
                   : CP_W'(unit_q);

  always_comb begin
    if (char_cp < CP_W'(21'h80)) begin
      nb = NB_W'(1);
    end else if (char_cp < CP_W'(21'h800)) begin
      nb = NB_W'(2);
    end else if (char_cp < CP_W'(21'h10000)) begin
      nb = NB_W'(3);
    end else begin
      nb = NB_W'(4);
    end
  end

  // capacity is clipped to the range of the byte counter
  assign lim     = CMP_W'(1) << COUNT_BITS;
  assign cap_ext = CMP_W'(cap_q);
  assign eff_cap = (cap_ext < lim) ? cap_ext : lim;
  assign sum     = CMP_W'(count_q) + CMP_W'(nb);
  assign fits    = (sum < eff_cap);

  // next phase
  always_comb begin
    ph_d     = ph_q;
    item_v_d = item_v_q;
    unit_d   = unit_q;
    last_d   = last_q;
    fin      = 1'b0;
    if (step) begin
      unique case (ph_q)
        PH_HELD: begin
          if (!fits || is_low) begin
            if (last_q) ph_d = PH_END;
            else fin = 1'b1;
          end else begin
            ph_d = PH_UNIT;
          end
        end
        PH_UNIT: begin
          if (last_q) ph_d = PH_END;
          else fin = 1'b1;
        end
        PH_END: begin
          fin = 1'b1;
        end
        default: fin = 1'b1;
      endcase
    end
    if (fin) begin
      item_v_d = 1'b0;
    end
    accept = in_i.valid && (!item_v_q || fin);
    if (accept) begin
      item_v_d = 1'b1;
      unit_d   = ~in_i.code_unit;
      last_d   = in_i.last_unit;
      ph_d     = (held_d && !stopped_d) ? PH_HELD : PH_UNIT;
    end
  end

  assign in_i.ready = !item_v_q || fin;

  // state updates and the word pushed to the queue
  always_comb begin
    held_d      = held_q;
    held_bits_d = held_bits_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    push_o      = 1'b0;
    push_cmd_o  = '0;
    if (step) begin
      unique case (ph_q)
        PH_HELD: begin
          held_d = 1'b0;
          if (fits) begin
            push_o        = 1'b1;
            push_cmd_o.cp = char_cp;
            push_cmd_o.nb = nb;
            count_d       = count_q + COUNT_BITS'(nb);
          end else begin
            stopped_d = 1'b1;
          end
        end
        PH_UNIT: begin
          if (!stopped_q) begin
            if (is_high && !last_q) begin
              held_d      = 1'b1;
              held_bits_d = unit_q[9:0];
            end else if (fits) begin
              push_o        = 1'b1;
              push_cmd_o.cp = char_cp;
              push_cmd_o.nb = nb;
              count_d       = count_q + COUNT_BITS'(nb);
            end else begin
              stopped_d = 1'b1;
              held_d    = 1'b0;
            end
          end
        end
        PH_END: begin
          push_o            = 1'b1;
          push_cmd_o.is_end = 1'b1;
          push_cmd_o.nb     = NB_W'(1);
          push_cmd_o.count  = CAP_W'(count_q);
          push_cmd_o.trunc  = stopped_q;
          held_d            = 1'b0;
          held_bits_d       = '0;
          count_d           = '0;
          stopped_d         = 1'b0;
        end
        default: begin
          held_d = held_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q    <= 1'b0;
      ph_q        <= PH_UNIT;
      held_q      <= 1'b0;
      held_bits_q <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      cap_q       <= CAP_RESET;
    end else begin
      item_v_q    <= item_v_d;
      ph_q        <= ph_d;
      held_q      <= held_d;
      held_bits_q <= held_bits_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    last_q <= last_d;
  end

endmodule

@@ design/u16u8_back.sv @@
module u16u8_back
  import u16u8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  cmd_t       head_cmd_i,
  output logic       pop_o,
  u16u8_out_if.source out_o
);

  localparam logic [0:0] LEAD1 = 1'b0;
  localparam logic [2:0] LEAD2 = 3'b110;
  localparam logic [3:0] LEAD3 = 4'b1110;
  localparam logic [4:0] LEAD4 = 5'b11110;
  localparam logic [1:0] CONT  = 2'b10;

  function automatic logic [7:0] enc_byte(logic [CP_W-1:0] cp, logic [NB_W-1:0] nb,
                                          logic [1:0] k);
    logic [1:0] sh;
    logic [5:0] grp;
    sh = 2'(nb - NB_W'(1) - NB_W'(k));
    unique case (sh)
      2'd0:    grp = cp[5:0];
      2'd1:    grp = cp[11:6];
      default: grp = cp[17:12];
    endcase
    if (k == 2'd0) begin
      unique case (nb)
        NB_W'(1): enc_byte = {LEAD1, cp[6:0]};
        NB_W'(2): enc_byte = {LEAD2, cp[10:6]};
        NB_W'(3): enc_byte = {LEAD3, cp[15:12]};
        default:  enc_byte = {LEAD4, cp[20:18]};
      endcase
    end else begin
      enc_byte = {CONT, grp};
    end
  endfunction

  logic [1:0]  idx_q, idx_d;
  logic        ov_q, ov_d;
  logic [7:0]  byte_q, byte_d;
  logic        eos_q, eos_d;
  logic [23:0] cnt_q, cnt_d;
  logic        tr_q, tr_d;
  logic        slot_free;
  logic        last_byte;

  assign slot_free = !ov_q || out_o.ready;
  assign last_byte = (idx_q == 2'(head_cmd_i.nb - NB_W'(1)));

  always_comb begin
    idx_d  = idx_q;
    ov_d   = ov_q;
    byte_d = byte_q;
    eos_d  = eos_q;
    cnt_d  = cnt_q;
    tr_d   = tr_q;
    pop_o  = 1'b0;
    if (slot_free && head_valid_i) begin
      ov_d   = 1'b1;
      byte_d = head_cmd_i.is_end ? 8'd0 : enc_byte(head_cmd_i.cp, head_cmd_i.nb, idx_q);
      eos_d  = head_cmd_i.is_end;
      cnt_d  = head_cmd_i.is_end ? head_cmd_i.count : '0;
      tr_d   = head_cmd_i.is_end && head_cmd_i.trunc;
      if (last_byte || head_cmd_i.is_end) begin
        pop_o = 1'b1;
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.out_byte      = byte_q;
  assign out_o.end_of_string = eos_q;
  assign out_o.written_count = cnt_q;
  assign out_o.truncated     = tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    eos_q  <= eos_d;
    cnt_q  <= cnt_d;
    tr_q   <= tr_d;
  end

endmodule
